// ===== rtl/icalc_pkg.sv =====
`timescale 1ns / 1ps
package icalc_pkg;

  localparam int DataW = 32;

  localparam logic [2:0] CMD_ADD = 3'd0;
  localparam logic [2:0] CMD_SUB = 3'd1;
  localparam logic [2:0] CMD_MUL = 3'd2;
  localparam logic [2:0] CMD_DIV = 3'd3;
  localparam logic [2:0] CMD_FACT = 3'd4;
  localparam logic [2:0] CMD_FIB = 3'd5;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_DIVZERO = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;
  localparam logic [1:0] ST_UNKNOWN = 2'd3;

  localparam logic [31:0] FACT_MAX_ARG = 32'd12;
  localparam logic [31:0] FIB_MAX_ARG = 32'd47;

  // One pipeline slot; rem/quo/dvs are the divider working set.
  typedef struct packed {
    logic        valid;
    logic        is_div;
    logic        neg;
    logic [1:0]  status;
    logic [31:0] res;
    logic [31:0] rem;
    logic [31:0] quo;
    logic [31:0] dvs;
  } pipe_t;

  function automatic logic [31:0] fact_rom(input logic [3:0] n);
    logic [31:0] v;
    case (n)
      4'd0:    v = 32'd1;
      4'd1:    v = 32'd1;
      4'd2:    v = 32'd2;
      4'd3:    v = 32'd6;
      4'd4:    v = 32'd24;
      4'd5:    v = 32'd120;
      4'd6:    v = 32'd720;
      4'd7:    v = 32'd5040;
      4'd8:    v = 32'd40320;
      4'd9:    v = 32'd362880;
      4'd10:   v = 32'd3628800;
      4'd11:   v = 32'd39916800;
      4'd12:   v = 32'd479001600;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

  // fib(1) = 0, fib(2) = 1
  function automatic logic [31:0] fib_rom(input logic [5:0] n);
    logic [31:0] v;
    case (n)
      6'd1:    v = 32'd0;
      6'd2:    v = 32'd1;
      6'd3:    v = 32'd1;
      6'd4:    v = 32'd2;
      6'd5:    v = 32'd3;
      6'd6:    v = 32'd5;
      6'd7:    v = 32'd8;
      6'd8:    v = 32'd13;
      6'd9:    v = 32'd21;
      6'd10:   v = 32'd34;
      6'd11:   v = 32'd55;
      6'd12:   v = 32'd89;
      6'd13:   v = 32'd144;
      6'd14:   v = 32'd233;
      6'd15:   v = 32'd377;
      6'd16:   v = 32'd610;
      6'd17:   v = 32'd987;
      6'd18:   v = 32'd1597;
      6'd19:   v = 32'd2584;
      6'd20:   v = 32'd4181;
      6'd21:   v = 32'd6765;
      6'd22:   v = 32'd10946;
      6'd23:   v = 32'd17711;
      6'd24:   v = 32'd28657;
      6'd25:   v = 32'd46368;
      6'd26:   v = 32'd75025;
      6'd27:   v = 32'd121393;
      6'd28:   v = 32'd196418;
      6'd29:   v = 32'd317811;
      6'd30:   v = 32'd514229;
      6'd31:   v = 32'd832040;
      6'd32:   v = 32'd1346269;
      6'd33:   v = 32'd2178309;
      6'd34:   v = 32'd3524578;
      6'd35:   v = 32'd5702887;
      6'd36:   v = 32'd9227465;
      6'd37:   v = 32'd14930352;
      6'd38:   v = 32'd24157817;
      6'd39:   v = 32'd39088169;
      6'd40:   v = 32'd63245986;
      6'd41:   v = 32'd102334155;
      6'd42:   v = 32'd165580141;
      6'd43:   v = 32'd267914296;
      6'd44:   v = 32'd433494437;
      6'd45:   v = 32'd701408733;
      6'd46:   v = 32'd1134903170;
      6'd47:   v = 32'd1836311903;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/integer_calculator_alu.sv =====
`timescale 1ns / 1ps
// Pipeline: decode stage, 32 one-bit divider stages and output register,
// passed through by every operation.
// Throughput: one transfer per cycle; the whole pipe holds while the output
// is stalled, so nothing is dropped or repeated.
// Reset (rst, synchronous, active high) clears all valid bits; no other state.
module integer_calculator_alu
  import icalc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  cmd,
  input  logic [31:0] operand_a,
  input  logic [31:0] operand_b,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] result,
  output logic [1:0]  status
);

  // Global advance: every stage moves together unless the output register
  // holds a result nobody has taken yet.
  logic  en;
  pipe_t chain [0:DataW];
  pipe_t last;

  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;

  // Stage 0: decode, add/sub/multiply, factorial and Fibonacci tables,
  // and divider operand magnitudes.
  icalc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (in_valid),
    .cmd       (cmd),
    .operand_a (operand_a),
    .operand_b (operand_b),
    .q         (chain[0])
  );

  // Divider: one quotient bit per stage, MSB first. Non-divide items just
  // ride along with their result already settled.
  for (genvar i = 0; i < DataW; i++) begin : g_div
    icalc_div_stage u_stage (
      .clk (clk),
      .rst (rst),
      .en  (en),
      .p   (chain[i]),
      .q   (chain[i+1])
    );
  end

  assign last = chain[DataW];

  // Output register: sign fix of the quotient and final select.
  // Minimum / -1 comes out as the minimum again, by wrap.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= last.valid;
      status    <= last.status;
      if (last.is_div) begin
        result <= last.neg ? (32'd0 - last.quo) : last.quo;
      end else begin
        result <= last.res;
      end
    end
  end

endmodule

// ===== rtl/icalc_front.sv =====
`timescale 1ns / 1ps
module icalc_front
  import icalc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        in_valid,
  input  logic [2:0]  cmd,
  input  logic [31:0] operand_a,
  input  logic [31:0] operand_b,
  output pipe_t       q
);

  pipe_t d;
  logic  a_neg;
  logic  b_neg;
  logic  fact_ok;
  logic  fib_ok;

  assign a_neg   = operand_a[31];
  assign b_neg   = operand_b[31];
  assign fact_ok = !a_neg && (operand_a <= FACT_MAX_ARG);
  assign fib_ok  = !a_neg && (operand_a != 32'd0) && (operand_a <= FIB_MAX_ARG);

  always_comb begin
    d        = '0;
    d.valid  = in_valid;
    d.neg    = a_neg ^ b_neg;
    d.quo    = a_neg ? (32'd0 - operand_a) : operand_a;
    d.dvs    = b_neg ? (32'd0 - operand_b) : operand_b;
    d.status = ST_OK;
    case (cmd)
      CMD_ADD: d.res = operand_a + operand_b;
      CMD_SUB: d.res = operand_a - operand_b;
      CMD_MUL: d.res = operand_a * operand_b;
      CMD_DIV: begin
        if (operand_b == 32'd0) begin
          d.status = ST_DIVZERO;
        end else begin
          d.is_div = 1'b1;
        end
      end
      CMD_FACT: begin
        if (fact_ok) begin
          d.res = fact_rom(operand_a[3:0]);
        end else begin
          d.status = ST_RANGE;
        end
      end
      CMD_FIB: begin
        if (fib_ok) begin
          d.res = fib_rom(operand_a[5:0]);
        end else begin
          d.status = ST_RANGE;
        end
      end
      default: d.status = ST_UNKNOWN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q.valid <= 1'b0;
    end else if (en) begin
      q <= d;
    end
  end

endmodule

// ===== rtl/icalc_div_stage.sv =====
`timescale 1ns / 1ps
module icalc_div_stage
  import icalc_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  en,
  input  pipe_t p,
  output pipe_t q
);

  // one restoring-division bit per stage
  pipe_t       d;
  logic [32:0] trial;
  logic [32:0] diff;
  logic        ge;

  assign trial = {p.rem, p.quo[31]};
  assign diff  = trial - {1'b0, p.dvs};
  assign ge    = !diff[32];

  always_comb begin
    d = p;
    if (p.is_div) begin
      d.rem = ge ? diff[31:0] : trial[31:0];
      d.quo = {p.quo[30:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q.valid <= 1'b0;
    end else if (en) begin
      q <= d;
    end
  end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
  import icalc_pkg::*;

  // Unknown operation codes; the package names only the six real ones.
  localparam logic [2:0] CMD_UNK6 = 3'd6;
  localparam logic [2:0] CMD_UNK7 = 3'd7;
  localparam int LATENCY = 34;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [31:0] value;
    logic [1:0]  code;
  } calc_out_t;

  // Predicts each transfer's result and matches outputs in order.
  class calc_scoreboard;
    calc_out_t pending[$];
    int errors;
    int checked;

    function calc_out_t compute(logic [2:0] op, logic [31:0] a, logic [31:0] b);
      calc_out_t r;
      logic [31:0] ma, mb, q;
      longint unsigned p, prev, cur, nxt;
      r.value = '0;
      r.code = ST_OK;
      case (op)
        CMD_ADD: r.value = a + b;
        CMD_SUB: r.value = a - b;
        CMD_MUL: r.value = a * b;
        CMD_DIV: begin
          if (b == 0) begin
            r.code = ST_DIVZERO;
          end else begin
            ma = a[31] ? -a : a;
            mb = b[31] ? -b : b;
            q = ma / mb;
            r.value = (a[31] != b[31]) ? -q : q;
          end
        end
        CMD_FACT: begin
          // stays valid while the product fits in a positive word
          p = 1;
          if (a[31]) begin
            r.code = ST_RANGE;
          end else begin
            for (longint unsigned k = 2; k <= a && r.code == ST_OK; k++) begin
              if (p > 64'h7fff_ffff / k) r.code = ST_RANGE;
              else p = p * k;
            end
            if (r.code == ST_OK) r.value = p[31:0];
          end
        end
        CMD_FIB: begin
          // fib(1)=0, fib(2)=1
          prev = 0;
          cur = 1;
          if (a[31] || a == 0) begin
            r.code = ST_RANGE;
          end else if (a == 1) begin
            r.value = 0;
          end else begin
            for (longint unsigned k = 3; k <= a && r.code == ST_OK; k++) begin
              if (cur > 64'h7fff_ffff - prev) begin
                r.code = ST_RANGE;
              end else begin
                nxt = prev + cur;
                prev = cur;
                cur = nxt;
              end
            end
            if (r.code == ST_OK) r.value = cur[31:0];
          end
        end
        default: r.code = ST_UNKNOWN;
      endcase
      return r;
    endfunction

    function void note_input(logic [2:0] op, logic [31:0] a, logic [31:0] b);
      pending.push_back(compute(op, a, b));
    endfunction

    function void check_output(logic [31:0] value, logic [1:0] code);
      calc_out_t e;
      if (pending.size() == 0) begin
        $error("unexpected result: result=%0d status=%0d", $signed(value), code);
        errors++;
        return;
      end
      e = pending.pop_front();
      checked++;
      if (value !== e.value) begin
        $error("result: expected %0d, got %0d", $signed(e.value), $signed(value));
        errors++;
      end
      if (code !== e.code) begin
        $error("status: expected %0d, got %0d", e.code, code);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] cmd = '0;
  logic [31:0] operand_a = '0;
  logic [31:0] operand_b = '0;
  logic out_valid;
  logic out_stall = 1'b1;
  logic [31:0] result;
  logic [1:0] status;

  calc_scoreboard board = new();
  int send_idle_pct = 0;   // percent of cycles the sender holds off
  int recv_idle_pct = 0;   // percent of cycles the receiver stalls
  int hold_cycles = 0;     // forced receiver hold-off, counted below
  int cycle_count = 0;
  int sent = 0;

  always #5 clk = ~clk;

  integer_calculator_alu dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .cmd(cmd), .operand_a(operand_a), .operand_b(operand_b),
    .out_valid(out_valid), .out_stall(out_stall),
    .result(result), .status(status)
  );

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Output side: check each transfer, then choose next cycle's stall.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) board.check_output(result, status);
    if (rst) begin
      out_stall <= 1'b1;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Offer one item; hold it until the block takes it. Valid drops only
  // when the sender idles or drains, so back-to-back items keep it high.
  task automatic send_item(input logic [2:0] op, input logic [31:0] a,
                           input logic [31:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd <= op;
    operand_a <= a;
    operand_b <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_input(op, a, b);
    sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_operand();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return $urandom_range(20) - 10;
      default: return $urandom;
    endcase
  endfunction

  task automatic random_items(input int count);
    logic [2:0] op;
    logic [31:0] a;
    for (int i = 0; i < count; i++) begin
      op = 3'($urandom_range(7));
      a = rand_operand();
      // factorial and fibonacci mostly get arguments around their valid range
      if ((op == CMD_FACT || op == CMD_FIB) && $urandom_range(3) != 0)
        a = $urandom_range(50);
      send_item(op, a, rand_operand());
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed corners: every operation, wrap cases, range edges.
    send_item(CMD_ADD, 32'h7fff_ffff, 32'd1);
    send_item(CMD_ADD, 32'h8000_0000, 32'hffff_ffff);
    send_item(CMD_SUB, 32'h8000_0000, 32'd1);
    send_item(CMD_SUB, 32'd0, 32'h8000_0000);
    send_item(CMD_MUL, 32'h7fff_ffff, 32'h7fff_ffff);
    send_item(CMD_MUL, 32'h8000_0000, 32'hffff_ffff);
    send_item(CMD_DIV, 32'd7, 32'd0);
    send_item(CMD_DIV, 32'h8000_0000, 32'hffff_ffff);
    send_item(CMD_DIV, -32'sd7, 32'd2);
    send_item(CMD_DIV, 32'd7, -32'sd2);
    send_item(CMD_DIV, 32'h8000_0000, 32'h7fff_ffff);
    send_item(CMD_FACT, 32'd0, 32'hffff_ffff);
    send_item(CMD_FACT, 32'd12, 32'd0);
    send_item(CMD_FACT, 32'd13, 32'd0);
    send_item(CMD_FACT, 32'hffff_ffff, 32'd0);
    send_item(CMD_FIB, 32'd0, 32'd0);
    send_item(CMD_FIB, 32'd1, 32'd0);
    send_item(CMD_FIB, 32'd2, 32'd0);
    send_item(CMD_FIB, 32'd47, 32'd0);
    send_item(CMD_FIB, 32'd48, 32'd0);
    send_item(CMD_FIB, 32'h8000_0000, 32'd0);
    send_item(CMD_UNK6, 32'd5, 32'd5);
    send_item(CMD_UNK7, 32'hffff_ffff, 32'hffff_ffff);
    // sender pauses until every result is back
    drain();

    // Long receiver hold-off while the sender keeps offering: pipe fills.
    hold_cycles <= 150;
    random_items(80);
    drain();

    send_idle_pct = 7;
    recv_idle_pct = 58;
    random_items(240);
    send_idle_pct = 58;
    recv_idle_pct = 7;
    random_items(240);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_items(240);
    drain();
    repeat (LATENCY + 10) @(posedge clk);

    $display("Covered %0d transfers, %0d results checked: all ops, corners, stalls.",
             sent, board.checked);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/icalc_pkg.sv
rtl/icalc_front.sv
rtl/icalc_div_stage.sv
rtl/integer_calculator_alu.sv
test/testbench.sv
